@@ design/assert_macros.svh @@
// Assertion helpers for the pitch controller RTL (included by the sequencer).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PAPC_ASSERT(lbl, clk, rst, prop) \
    lbl: assert property (@(posedge clk) disable iff (rst) prop) \
        else $error("pitch controller assertion failed");
`define PAPC_ASSERT_NEVER(lbl, clk, rst, expr) \
    lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
        else $error("pitch controller forbidden condition");
`else
`define PAPC_ASSERT(lbl, clk, rst, prop)
`define PAPC_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

@@ design/papc_pkg.sv @@
package papc_pkg;

    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 24;
    localparam int DT_W      = 16;
    localparam int MUL_A_W   = GAIN_W + 1;
    localparam int MUL_B_W   = DATA_W + 1;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int SUM_W     = DATA_W + 2;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 4;

    localparam logic [STEP_W-1:0] INIT_STEP = 4'd11;

    localparam logic [GAIN_W-1:0]        LAG_RESET  = 24'd65536;
    localparam logic signed [DATA_W-1:0] PMAX_RESET = 32'sd1769472;
    localparam logic signed [DATA_W-1:0] PMIN_RESET = 32'sd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_PROP_GAIN,
        CFG_SPEED_INT_GAIN,
        CFG_POWER_PROP_GAIN,
        CFG_POWER_INT_GAIN,
        CFG_COMPENSATION_GAIN,
        CFG_INVERSE_LAG_TIME,
        CFG_PITCH_MAX,
        CFG_PITCH_MIN
    } cfg_reg_t;

    typedef enum logic {ST_IDLE, ST_RUN} seq_state_t;

    // ALU operand selects: result = a + b - c
    typedef enum logic [1:0] {OPA_PROD, OPA_ORDERED, OPA_SC, OPA_TGT} opa_t;
    typedef enum logic [2:0] {
        OPB_ZERO, OPB_SPEED, OPB_PINT, OPB_SINT, OPB_PC, OPB_PITCH
    } opb_t;
    typedef enum logic [1:0] {OPC_ZERO, OPC_ACTIVE, OPC_SREF, OPC_PITCH} opc_t;
    typedef enum logic [1:0] {POST_NONE, POST_SAT, POST_LIM, POST_RATE} post_t;
    typedef enum logic [3:0] {
        DST_NONE, DST_PE, DST_SE, DST_PC, DST_SC, DST_TGT, DST_DIFF,
        DST_PINT, DST_SINT, DST_DTH, DST_PITCH
    } dst_t;

    typedef enum logic [2:0] {
        MA_COMP, MA_SPG, MA_PPG, MA_SIG, MA_PIG, MA_ILT, MA_DT
    } mula_t;
    typedef enum logic [2:0] {
        MB_PE, MB_SE, MB_DIFF, MB_PRATE, MB_SRATE, MB_DTH
    } mulb_t;
    typedef enum logic [1:0] {CAP_NONE, CAP_PRATE, CAP_SRATE} cap_t;
    typedef enum logic [1:0] {SQ_NEXT, SQ_BR_INIT, SQ_DONE} seqop_t;

    typedef struct packed {
        opa_t              a_sel;
        opb_t              b_sel;
        opc_t              c_sel;
        post_t             post;
        dst_t              dst;
        mula_t             ma;
        mulb_t             mb;
        logic              mul_en;
        cap_t              cap;
        logic              init_op;
        seqop_t            seq;
        logic [STEP_W-1:0] target;
    } ucode_t;

    typedef struct packed {
        logic   en;
        logic   load_in;
        ucode_t uc;
    } dp_ctrl_t;

    localparam ucode_t UCODE_NOP = '{
        a_sel: OPA_PROD, b_sel: OPB_ZERO, c_sel: OPC_ZERO, post: POST_NONE,
        dst: DST_NONE, ma: MA_COMP, mb: MB_PE, mul_en: 1'b0, cap: CAP_NONE,
        init_op: 1'b0, seq: SQ_NEXT, target: '0
    };

    // Microprogram. A product issued in step k is consumed in step k+1.
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] addr);
        ucode_t w;
        w = UCODE_NOP;
        case (addr)
            4'd0: begin
                w.a_sel = OPA_ORDERED; w.c_sel = OPC_ACTIVE;
                w.post = POST_SAT; w.dst = DST_PE;
                w.seq = SQ_BR_INIT; w.target = INIT_STEP;
            end
            4'd1: begin
                w.ma = MA_COMP; w.mb = MB_PE; w.mul_en = 1'b1;
            end
            4'd2: begin
                w.a_sel = OPA_PROD; w.b_sel = OPB_SPEED; w.c_sel = OPC_SREF;
                w.post = POST_SAT; w.dst = DST_SE;
                w.ma = MA_PPG; w.mb = MB_PE; w.mul_en = 1'b1;
            end
            4'd3: begin
                w.a_sel = OPA_PROD; w.b_sel = OPB_PINT; w.post = POST_LIM; w.dst = DST_PC;
                w.ma = MA_SPG; w.mb = MB_SE; w.mul_en = 1'b1;
            end
            4'd4: begin
                w.a_sel = OPA_PROD; w.b_sel = OPB_SINT; w.post = POST_LIM; w.dst = DST_SC;
                w.ma = MA_PIG; w.mb = MB_PE; w.mul_en = 1'b1;
            end
            4'd5: begin
                w.a_sel = OPA_SC; w.b_sel = OPB_PC; w.post = POST_LIM; w.dst = DST_TGT;
                w.cap = CAP_PRATE;
                w.ma = MA_SIG; w.mb = MB_SE; w.mul_en = 1'b1;
            end
            4'd6: begin
                w.a_sel = OPA_TGT; w.c_sel = OPC_PITCH; w.post = POST_NONE; w.dst = DST_DIFF;
                w.cap = CAP_SRATE;
                w.ma = MA_DT; w.mb = MB_PRATE; w.mul_en = 1'b1;
            end
            4'd7: begin
                w.a_sel = OPA_PROD; w.b_sel = OPB_PINT; w.post = POST_SAT; w.dst = DST_PINT;
                w.ma = MA_ILT; w.mb = MB_DIFF; w.mul_en = 1'b1;
            end
            4'd8: begin
                w.a_sel = OPA_PROD; w.post = POST_RATE; w.dst = DST_DTH;
                w.ma = MA_DT; w.mb = MB_SRATE; w.mul_en = 1'b1;
            end
            4'd9: begin
                w.a_sel = OPA_PROD; w.b_sel = OPB_SINT; w.post = POST_SAT; w.dst = DST_SINT;
                w.ma = MA_DT; w.mb = MB_DTH; w.mul_en = 1'b1;
            end
            4'd10: begin
                w.a_sel = OPA_PROD; w.b_sel = OPB_PITCH; w.post = POST_LIM; w.dst = DST_PITCH;
                w.seq = SQ_DONE;
            end
            INIT_STEP: begin
                w.init_op = 1'b1; w.seq = SQ_DONE;
            end
            default: begin
                w.seq = SQ_DONE;
            end
        endcase
        return w;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic [PROD_W-DATA_W:0] top_bits;
        top_bits = v[PROD_W-1:DATA_W-1];
        if (&top_bits || ~|top_bits) begin
            return v[DATA_W-1:0];
        end else if (v[PROD_W-1]) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

endpackage

@@ design/papc_sequencer.sv @@
`include "assert_macros.svh"

module papc_sequencer (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    output logic               m_valid,
    input  logic               m_ready,
    output papc_pkg::dp_ctrl_t ctrl
);
    import papc_pkg::*;

    seq_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              action_reg, action_next;
    logic              m_valid_reg, m_valid_next;
    ucode_t            uc;
    logic              at_done;
    logic              stall;
    logic              done_fire;
    logic              s_fire;

    assign uc        = ucode_rom(step_reg);
    assign at_done   = (state_reg == ST_RUN) && (uc.seq == SQ_DONE);
    // hold the last step while the previous result is still waiting
    assign stall     = at_done && m_valid_reg && !m_ready;
    assign done_fire = at_done && !stall;
    assign s_ready   = (state_reg == ST_IDLE) || done_fire;
    assign s_fire    = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN: begin
                if (!stall) begin
                    case (uc.seq)
                        SQ_NEXT: step_next = step_reg + STEP_W'(1);
                        SQ_BR_INIT: begin
                            step_next = action_reg ? uc.target : step_reg + STEP_W'(1);
                        end
                        SQ_DONE: begin
                            if (s_fire) begin
                                step_next = '0;
                            end else begin
                                state_next = ST_IDLE;
                            end
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl.en      = (state_reg == ST_RUN) && !stall;
        ctrl.load_in = s_fire;
        ctrl.uc      = uc;
        action_next  = s_fire ? s_action : action_reg;
        m_valid_next = done_fire || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            action_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            action_reg  <= action_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `PAPC_ASSERT(a_accept_starts, aclk, !aresetn, s_fire |=> (state_reg == ST_RUN) && (step_reg == '0))
    `PAPC_ASSERT(a_step_range, aclk, !aresetn, (state_reg == ST_RUN) |-> (step_reg <= INIT_STEP))
    `PAPC_ASSERT(a_valid_from_done, aclk, !aresetn, $rose(m_valid_reg) |-> $past(done_fire))
    `PAPC_ASSERT_NEVER(a_no_overwrite, aclk, !aresetn, done_fire && m_valid_reg && !m_ready)

endmodule

@@ design/papc_datapath.sv @@
module papc_datapath #(
    parameter int RATE_UP_LIMIT   = 655360,
    parameter int RATE_DOWN_LIMIT = -655360,
    parameter int FRACTION_BITS   = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  papc_pkg::dp_ctrl_t                     ctrl,
    input  logic [papc_pkg::GAIN_W-1:0]            speed_prop_gain,
    input  logic [papc_pkg::GAIN_W-1:0]            speed_int_gain,
    input  logic [papc_pkg::GAIN_W-1:0]            power_prop_gain,
    input  logic [papc_pkg::GAIN_W-1:0]            power_int_gain,
    input  logic signed [papc_pkg::GAIN_W-1:0]     compensation_gain,
    input  logic [papc_pkg::GAIN_W-1:0]            inverse_lag_time,
    input  logic signed [papc_pkg::DATA_W-1:0]     pitch_max,
    input  logic signed [papc_pkg::DATA_W-1:0]     pitch_min,
    input  logic signed [papc_pkg::DATA_W-1:0]     s_turbine_speed,
    input  logic signed [papc_pkg::DATA_W-1:0]     s_ordered_power,
    input  logic signed [papc_pkg::DATA_W-1:0]     s_active_reference,
    input  logic signed [papc_pkg::DATA_W-1:0]     s_speed_ref,
    input  logic                                   s_speed_ref_valid,
    input  logic signed [papc_pkg::DATA_W-1:0]     s_initial_pitch,
    input  logic [papc_pkg::DT_W-1:0]              s_delta_t,
    output logic signed [papc_pkg::DATA_W-1:0]     m_pitch_angle,
    output logic                                   m_speed_windup,
    output logic                                   m_power_windup,
    output logic                                   m_init_error
);
    import papc_pkg::*;

    // held copy of the item in progress
    logic signed [DATA_W-1:0] speed_reg, ordered_reg, active_reg, sref_reg, ipitch_reg;
    logic                     sref_valid_reg;
    logic [DT_W-1:0]          dt_reg;

    // scratch registers
    logic signed [DATA_W-1:0] pe_reg, se_reg, sc_reg, pc_reg, tgt_reg, dth_reg;
    logic signed [DATA_W-1:0] prate_reg, srate_reg;
    logic signed [DATA_W:0]   diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_dt_reg;

    // controller state
    logic signed [DATA_W-1:0] pitch_reg, pitch_next;
    logic signed [DATA_W-1:0] sint_reg, sint_next;
    logic signed [DATA_W-1:0] pint_reg, pint_next;
    logic signed [DATA_W-1:0] sis_reg, sis_next;

    logic signed [DATA_W-1:0] m_pitch_angle_reg;
    logic                     m_speed_windup_reg, m_power_windup_reg, m_init_error_reg;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]  prod_sh;
    logic signed [DATA_W-1:0]  mval;
    logic signed [DATA_W-1:0]  opa, opb, opc;
    logic signed [SUM_W-1:0]   sum, lo_x, hi_x, up_x, dn_x, lim_v, rate_v;
    logic signed [DATA_W-1:0]  sat_v;
    logic signed [DATA_W:0]    alu_res;
    logic signed [DATA_W-1:0]  alu32;
    logic                      swind, pwind, init_ok, done;

    // shared multiplier
    always_comb begin
        case (ctrl.uc.ma)
            MA_COMP: mul_a = {compensation_gain[GAIN_W-1], compensation_gain};
            MA_SPG:  mul_a = {1'b0, speed_prop_gain};
            MA_PPG:  mul_a = {1'b0, power_prop_gain};
            MA_SIG:  mul_a = {1'b0, speed_int_gain};
            MA_PIG:  mul_a = {1'b0, power_int_gain};
            MA_ILT:  mul_a = {1'b0, inverse_lag_time};
            MA_DT:   mul_a = MUL_A_W'(dt_reg);
            default: mul_a = '0;
        endcase
        case (ctrl.uc.mb)
            MB_PE:    mul_b = {pe_reg[DATA_W-1], pe_reg};
            MB_SE:    mul_b = {se_reg[DATA_W-1], se_reg};
            MB_DIFF:  mul_b = diff_reg;
            MB_PRATE: mul_b = {prate_reg[DATA_W-1], prate_reg};
            MB_SRATE: mul_b = {srate_reg[DATA_W-1], srate_reg};
            MB_DTH:   mul_b = {dth_reg[DATA_W-1], dth_reg};
            default:  mul_b = '0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // floor shift of the registered product, then saturate
    assign prod_sh = prod_dt_reg ? (prod_reg >>> DT_W) : (prod_reg >>> FRACTION_BITS);
    assign mval    = sat32(prod_sh);

    // ALU: a + b - c, then saturate, clamp, or pass through
    always_comb begin
        case (ctrl.uc.a_sel)
            OPA_PROD:    opa = mval;
            OPA_ORDERED: opa = ordered_reg;
            OPA_SC:      opa = sc_reg;
            OPA_TGT:     opa = tgt_reg;
            default:     opa = '0;
        endcase
        case (ctrl.uc.b_sel)
            OPB_ZERO:  opb = '0;
            OPB_SPEED: opb = speed_reg;
            OPB_PINT:  opb = pint_reg;
            OPB_SINT:  opb = sint_reg;
            OPB_PC:    opb = pc_reg;
            OPB_PITCH: opb = pitch_reg;
            default:   opb = '0;
        endcase
        case (ctrl.uc.c_sel)
            OPC_ZERO:   opc = '0;
            OPC_ACTIVE: opc = active_reg;
            OPC_SREF:   opc = sref_valid_reg ? sref_reg : sis_reg;
            OPC_PITCH:  opc = pitch_reg;
            default:    opc = '0;
        endcase
    end

    assign sum  = SUM_W'(opa) + SUM_W'(opb) - SUM_W'(opc);
    assign lo_x = SUM_W'(pitch_min);
    assign hi_x = SUM_W'(pitch_max);
    assign up_x = SUM_W'(RATE_UP_LIMIT);
    assign dn_x = SUM_W'(RATE_DOWN_LIMIT);

    // raise to the lower limit first, so the upper limit wins when they cross
    always_comb begin
        lim_v = sum;
        if (lim_v < lo_x) lim_v = lo_x;
        if (lim_v > hi_x) lim_v = hi_x;
        rate_v = sum;
        if (rate_v < dn_x) rate_v = dn_x;
        if (rate_v > up_x) rate_v = up_x;
    end

    assign sat_v = sat32(PROD_W'(sum));

    always_comb begin
        case (ctrl.uc.post)
            POST_NONE: alu_res = sum[DATA_W:0];
            POST_SAT:  alu_res = {sat_v[DATA_W-1], sat_v};
            POST_LIM:  alu_res = lim_v[DATA_W:0];
            POST_RATE: alu_res = rate_v[DATA_W:0];
            default:   alu_res = sum[DATA_W:0];
        endcase
    end

    assign alu32 = alu_res[DATA_W-1:0];

    assign swind = ((sc_reg >= pitch_max) && (se_reg > 0)) ||
                   ((sc_reg <= pitch_min) && (se_reg < 0));
    assign pwind = ((pc_reg >= pitch_max) && (pe_reg > 0)) ||
                   ((pc_reg <= pitch_min) && (pe_reg < 0));
    assign init_ok = !((ipitch_reg < pitch_min) || (ipitch_reg > pitch_max));
    assign done    = ctrl.en && (ctrl.uc.seq == SQ_DONE);

    always_comb begin
        pitch_next = pitch_reg;
        sint_next  = sint_reg;
        pint_next  = pint_reg;
        sis_next   = sis_reg;
        if (ctrl.en) begin
            if (ctrl.uc.init_op) begin
                if (init_ok) begin
                    sis_next   = speed_reg;
                    pitch_next = ipitch_reg;
                    sint_next  = ipitch_reg;
                    pint_next  = '0;
                end
            end else begin
                case (ctrl.uc.dst)
                    DST_PINT:  pint_next  = alu32;
                    DST_SINT:  sint_next  = alu32;
                    DST_PITCH: pitch_next = alu32;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pitch_reg <= '0;
            sint_reg  <= '0;
            pint_reg  <= '0;
            sis_reg   <= '0;
        end else begin
            pitch_reg <= pitch_next;
            sint_reg  <= sint_next;
            pint_reg  <= pint_next;
            sis_reg   <= sis_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_in) begin
            speed_reg      <= s_turbine_speed;
            ordered_reg    <= s_ordered_power;
            active_reg     <= s_active_reference;
            sref_reg       <= s_speed_ref;
            sref_valid_reg <= s_speed_ref_valid;
            ipitch_reg     <= s_initial_pitch;
            dt_reg         <= s_delta_t;
        end
        if (ctrl.en && ctrl.uc.mul_en) begin
            prod_reg    <= mul_p;
            prod_dt_reg <= (ctrl.uc.ma == MA_DT);
        end
        if (ctrl.en) begin
            case (ctrl.uc.dst)
                DST_PE:   pe_reg   <= alu32;
                DST_SE:   se_reg   <= alu32;
                DST_PC:   pc_reg   <= alu32;
                DST_SC:   sc_reg   <= alu32;
                DST_TGT:  tgt_reg  <= alu32;
                DST_DIFF: diff_reg <= alu_res;
                DST_DTH:  dth_reg  <= alu32;
                default: ;
            endcase
            case (ctrl.uc.cap)
                CAP_PRATE: prate_reg <= pwind ? '0 : mval;
                CAP_SRATE: srate_reg <= swind ? '0 : mval;
                default: ;
            endcase
        end
        if (done) begin
            m_pitch_angle_reg  <= pitch_next;
            m_speed_windup_reg <= !ctrl.uc.init_op && swind;
            m_power_windup_reg <= !ctrl.uc.init_op && pwind;
            m_init_error_reg   <= ctrl.uc.init_op && !init_ok;
        end
    end

    assign m_pitch_angle  = m_pitch_angle_reg;
    assign m_speed_windup = m_speed_windup_reg;
    assign m_power_windup = m_power_windup_reg;
    assign m_init_error   = m_init_error_reg;

endmodule

@@ design/pitch_angle_pi_controller_top.sv @@
// Wind turbine pitch PI controller, signed Q15.16 datapath driven by a small
// microprogram. A step item (action 0) runs steps 0 to 10 and an init item (action 1)
// branches from step 0 to the init step. A step item runs its nine products one at a time
// through a single 25x33 multiplier followed by a shared add/saturate/clamp unit. The
// next item is taken in the last step of the current one, so back-to-back items run
// with no idle gap. Results sit in an output register; if it is still occupied the last
// step holds until the result is taken. Configuration registers are written through
// cfg_we/cfg_index/cfg_data, by the user only while idle; the block does not enforce it.
module pitch_angle_pi_controller_top #(
    parameter int RATE_UP_LIMIT   = 655360,
    parameter int RATE_DOWN_LIMIT = -655360,
    parameter int FRACTION_BITS   = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [papc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [papc_pkg::DATA_W-1:0]          cfg_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_action,
    input  logic signed [papc_pkg::DATA_W-1:0]   s_turbine_speed,
    input  logic signed [papc_pkg::DATA_W-1:0]   s_ordered_power,
    input  logic signed [papc_pkg::DATA_W-1:0]   s_active_reference,
    input  logic signed [papc_pkg::DATA_W-1:0]   s_speed_ref,
    input  logic                                 s_speed_ref_valid,
    input  logic signed [papc_pkg::DATA_W-1:0]   s_initial_pitch,
    input  logic [papc_pkg::DT_W-1:0]            s_delta_t,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [papc_pkg::DATA_W-1:0]   m_pitch_angle,
    output logic                                 m_speed_windup,
    output logic                                 m_power_windup,
    output logic                                 m_init_error
);
    import papc_pkg::*;

    logic [GAIN_W-1:0]        speed_prop_gain_reg, speed_prop_gain_next;
    logic [GAIN_W-1:0]        speed_int_gain_reg, speed_int_gain_next;
    logic [GAIN_W-1:0]        power_prop_gain_reg, power_prop_gain_next;
    logic [GAIN_W-1:0]        power_int_gain_reg, power_int_gain_next;
    logic signed [GAIN_W-1:0] compensation_gain_reg, compensation_gain_next;
    logic [GAIN_W-1:0]        inverse_lag_time_reg, inverse_lag_time_next;
    logic signed [DATA_W-1:0] pitch_max_reg, pitch_max_next;
    logic signed [DATA_W-1:0] pitch_min_reg, pitch_min_next;
    dp_ctrl_t                 ctrl;

    always_comb begin
        speed_prop_gain_next   = speed_prop_gain_reg;
        speed_int_gain_next    = speed_int_gain_reg;
        power_prop_gain_next   = power_prop_gain_reg;
        power_int_gain_next    = power_int_gain_reg;
        compensation_gain_next = compensation_gain_reg;
        inverse_lag_time_next  = inverse_lag_time_reg;
        pitch_max_next         = pitch_max_reg;
        pitch_min_next         = pitch_min_reg;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                CFG_SPEED_PROP_GAIN:   speed_prop_gain_next   = cfg_data[GAIN_W-1:0];
                CFG_SPEED_INT_GAIN:    speed_int_gain_next    = cfg_data[GAIN_W-1:0];
                CFG_POWER_PROP_GAIN:   power_prop_gain_next   = cfg_data[GAIN_W-1:0];
                CFG_POWER_INT_GAIN:    power_int_gain_next    = cfg_data[GAIN_W-1:0];
                CFG_COMPENSATION_GAIN: compensation_gain_next = cfg_data[GAIN_W-1:0];
                CFG_INVERSE_LAG_TIME:  inverse_lag_time_next  = cfg_data[GAIN_W-1:0];
                CFG_PITCH_MAX:         pitch_max_next         = cfg_data;
                CFG_PITCH_MIN:         pitch_min_next         = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_prop_gain_reg   <= '0;
            speed_int_gain_reg    <= '0;
            power_prop_gain_reg   <= '0;
            power_int_gain_reg    <= '0;
            compensation_gain_reg <= '0;
            inverse_lag_time_reg  <= LAG_RESET;
            pitch_max_reg         <= PMAX_RESET;
            pitch_min_reg         <= PMIN_RESET;
        end else begin
            speed_prop_gain_reg   <= speed_prop_gain_next;
            speed_int_gain_reg    <= speed_int_gain_next;
            power_prop_gain_reg   <= power_prop_gain_next;
            power_int_gain_reg    <= power_int_gain_next;
            compensation_gain_reg <= compensation_gain_next;
            inverse_lag_time_reg  <= inverse_lag_time_next;
            pitch_max_reg         <= pitch_max_next;
            pitch_min_reg         <= pitch_min_next;
        end
    end

    papc_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .ctrl     (ctrl)
    );

    papc_datapath #(
        .RATE_UP_LIMIT   (RATE_UP_LIMIT),
        .RATE_DOWN_LIMIT (RATE_DOWN_LIMIT),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .ctrl               (ctrl),
        .speed_prop_gain    (speed_prop_gain_reg),
        .speed_int_gain     (speed_int_gain_reg),
        .power_prop_gain    (power_prop_gain_reg),
        .power_int_gain     (power_int_gain_reg),
        .compensation_gain  (compensation_gain_reg),
        .inverse_lag_time   (inverse_lag_time_reg),
        .pitch_max          (pitch_max_reg),
        .pitch_min          (pitch_min_reg),
        .s_turbine_speed    (s_turbine_speed),
        .s_ordered_power    (s_ordered_power),
        .s_active_reference (s_active_reference),
        .s_speed_ref        (s_speed_ref),
        .s_speed_ref_valid  (s_speed_ref_valid),
        .s_initial_pitch    (s_initial_pitch),
        .s_delta_t          (s_delta_t),
        .m_pitch_angle      (m_pitch_angle),
        .m_speed_windup     (m_speed_windup),
        .m_power_windup     (m_power_windup),
        .m_init_error       (m_init_error)
    );

endmodule
